// ----- sv/tea_pkg.sv -----
// Package for the triangle edge adjacency unit: constants, types, commands.
package tea_pkg;

    localparam int MaxFaces = 1024;
    localparam int FaceW    = $clog2(MaxFaces);
    localparam int CountW   = FaceW + 1;
    localparam int VertW    = 16;
    localparam int NbrW     = 11;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_READ = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH_I,
        ST_WAIT_I,
        ST_EDGE,
        ST_FETCH_J,
        ST_WAIT_J,
        ST_CMP,
        ST_LINK,
        ST_RWAIT,
        ST_OUT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_face;
        logic clr_count;
        logic clr_entry;
        logic rd_i;
        logic lat_i;
        logic rd_j;
        logic link;
        logic rd_req;
        logic out_load;
        logic set_i0;
        logic inc_i;
        logic set_k0;
        logic inc_k;
        logic set_j;
        logic inc_j;
        logic set_e0;
        logic inc_e;
    } cmd_bus_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic i_done;
        logic k_last;
        logic k_matched;
        logic j_done;
        logic j_full_mask;
        logic e_hit;
        logic e_last;
    } sts_bus_t;

    function automatic logic [1:0] next_corner(input logic [1:0] k);
        case (k)
            2'd0:    next_corner = 2'd1;
            2'd1:    next_corner = 2'd2;
            default: next_corner = 2'd0;
        endcase
    endfunction

endpackage

// ----- sv/tea_ctrl.sv -----
// Controller state machine of the triangle edge adjacency unit.
module tea_ctrl
    import tea_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_command,
    input  logic     s_last_face,
    input  logic     out_busy,
    input  sts_bus_t sts,
    output cmd_bus_t cmd
);

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = !out_busy;
                if (s_valid && !out_busy) begin
                    if (s_command == CMD_READ) begin
                        cmd.rd_req = 1'b1;
                        state_next = ST_RWAIT;
                    end else begin
                        cmd.clr_count = done_reg;
                        cmd.load_face = 1'b1;
                        done_next     = 1'b0;
                        if (s_last_face) begin
                            cmd.set_i0 = 1'b1;
                            state_next = ST_CLEAR;
                        end
                    end
                end
            end
            // Wipe adjacency of each loaded face
            ST_CLEAR: begin
                if (sts.i_done) begin
                    cmd.set_i0 = 1'b1;
                    state_next = ST_FETCH_I;
                end else begin
                    cmd.clr_entry = 1'b1;
                    cmd.inc_i     = 1'b1;
                end
            end
            ST_FETCH_I: begin
                if (sts.i_done) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd_i   = 1'b1;
                    state_next = ST_WAIT_I;
                end
            end
            ST_WAIT_I: begin
                cmd.lat_i  = 1'b1;
                cmd.set_k0 = 1'b1;
                state_next = ST_EDGE;
            end
            ST_EDGE: begin
                if (sts.k_matched) begin
                    if (sts.k_last) begin
                        cmd.inc_i  = 1'b1;
                        state_next = ST_FETCH_I;
                    end else begin
                        cmd.inc_k = 1'b1;
                    end
                end else begin
                    cmd.set_j  = 1'b1;
                    state_next = ST_FETCH_J;
                end
            end
            ST_FETCH_J: begin
                if (sts.j_done) begin
                    state_next = ST_EDGE;
                    if (sts.k_last) begin
                        cmd.inc_i  = 1'b1;
                        state_next = ST_FETCH_I;
                    end else begin
                        cmd.inc_k = 1'b1;
                    end
                end else begin
                    cmd.rd_j   = 1'b1;
                    state_next = ST_WAIT_J;
                end
            end
            ST_WAIT_J: begin
                cmd.set_e0 = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.j_full_mask) begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_FETCH_J;
                end else if (sts.e_hit) begin
                    state_next = ST_LINK;
                end else if (sts.e_last) begin
                    cmd.inc_j  = 1'b1;
                    state_next = ST_FETCH_J;
                end else begin
                    cmd.inc_e = 1'b1;
                end
            end
            // Link writes face j; on the last edge face i is written back from ST_EDGE
            ST_LINK: begin
                cmd.link   = 1'b1;
                state_next = ST_EDGE;
                if (!sts.k_last) begin
                    cmd.inc_k = 1'b1;
                end
            end
            ST_RWAIT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                cmd.out_load = 1'b1;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/tea_dpath.sv -----
// Datapath of the triangle edge adjacency unit: face stores, counters, compare.
module tea_dpath
    import tea_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cmd_bus_t               cmd,
    output sts_bus_t               sts,
    input  logic [VertW-1:0]       s_vertex_0,
    input  logic [VertW-1:0]       s_vertex_1,
    input  logic [VertW-1:0]       s_vertex_2,
    input  logic [FaceW-1:0]       s_face_index,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic                   out_busy,
    output logic                   m_in_range,
    output logic signed [NbrW-1:0] m_neighbor_face_0,
    output logic signed [NbrW-1:0] m_neighbor_face_1,
    output logic signed [NbrW-1:0] m_neighbor_face_2,
    output logic [1:0]             m_neighbor_edge_0,
    output logic [1:0]             m_neighbor_edge_1,
    output logic [1:0]             m_neighbor_edge_2
);

    // Memories: vertices, and adjacency (a neighbor face and edge per edge, mask) per face
    logic [3*VertW-1:0]  vert_mem [MaxFaces];
    logic [3*FaceW-1:0]  nf_mem   [MaxFaces];
    logic [2:0]          nv_mem   [MaxFaces];   // neighbor valid per edge
    logic [5:0]          ne_mem   [MaxFaces];
    logic [2:0]          mask_mem [MaxFaces];

    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] i_reg;
    logic [CountW-1:0] j_reg;
    logic [1:0]        k_reg, e_reg;
    logic [2:0]        mask_i_reg;
    logic [3*VertW-1:0] vi_reg;
    logic [3*VertW-1:0] vrd_q;
    logic [2:0]        mrd_q;
    logic [3*FaceW-1:0] nf_q;
    logic [2:0]        nv_q;
    logic [5:0]        ne_q;
    logic              ok_reg;
    logic              vld_reg;

    logic [FaceW-1:0]  rd_addr;
    logic [FaceW-1:0]  wr_addr;
    logic              mem_rd;

    logic [FaceW-1:0]  ii, jj;
    assign ii = i_reg[FaceW-1:0];
    assign jj = j_reg[FaceW-1:0];

    // Vertex select helper
    function automatic logic [VertW-1:0] vsel(input logic [3*VertW-1:0] v,
                                              input logic [1:0] n);
        case (n)
            2'd0:    vsel = v[VertW-1:0];
            2'd1:    vsel = v[2*VertW-1:VertW];
            default: vsel = v[3*VertW-1:2*VertW];
        endcase
    endfunction

    // Counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load_face) begin
            if (cmd.clr_count) begin
                count_reg <= CountW'(1);
            end else if (count_reg != CountW'(MaxFaces)) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.set_i0)      i_reg <= '0;
        else if (cmd.inc_i)  i_reg <= i_reg + 1'b1;
        if (cmd.set_k0)      k_reg <= 2'd0;
        else if (cmd.inc_k)  k_reg <= k_reg + 2'd1;
        if (cmd.set_j)       j_reg <= i_reg + 1'b1;
        else if (cmd.inc_j)  j_reg <= j_reg + 1'b1;
        if (cmd.set_e0)      e_reg <= 2'd0;
        else if (cmd.inc_e)  e_reg <= e_reg + 2'd1;
        if (cmd.lat_i) begin
            vi_reg     <= vrd_q;
            mask_i_reg <= mrd_q;
        end else if (cmd.link) begin
            mask_i_reg <= mask_i_reg | (3'b001 << k_reg);
        end
    end

    // Memory addressing
    assign mem_rd  = cmd.rd_i || cmd.rd_j || cmd.rd_req;
    assign rd_addr = cmd.rd_i ? ii : (cmd.rd_j ? jj : s_face_index);

    always_ff @(posedge aclk) begin
        if (mem_rd) begin
            vrd_q <= vert_mem[rd_addr];
            mrd_q <= mask_mem[rd_addr];
            nf_q  <= nf_mem[rd_addr];
            nv_q  <= nv_mem[rd_addr];
            ne_q  <= ne_mem[rd_addr];
        end
    end

    // Vertex store write
    assign wr_addr = cmd.clr_count ? '0 : count_reg[FaceW-1:0];
    always_ff @(posedge aclk) begin
        if (cmd.load_face && (cmd.clr_count || count_reg != CountW'(MaxFaces))) begin
            vert_mem[wr_addr] <= {s_vertex_2, s_vertex_1, s_vertex_0};
        end
    end

    // Adjacency stores: clear pass, then read-modify-write on link
    logic [FaceW-1:0] lnk_addr;
    logic [3*FaceW-1:0] nf_w;
    logic [2:0]       nv_w;
    logic [5:0]       ne_w;
    logic [2:0]       mk_w;
    logic             adj_we;
    logic [FaceW-1:0] adj_addr;

    assign lnk_addr = jj;
    always_comb begin
        nf_w     = nf_q;
        nv_w     = nv_q;
        ne_w     = ne_q;
        mk_w     = mrd_q;
        adj_we   = cmd.clr_entry || cmd.link;
        adj_addr = cmd.clr_entry ? ii : lnk_addr;
        if (cmd.clr_entry) begin
            nv_w = '0;
            ne_w = '0;
            mk_w = '0;
        end else begin
            nf_w[e_reg*FaceW +: FaceW] = ii;
            nv_w[e_reg]                = 1'b1;
            ne_w[e_reg*2 +: 2]         = k_reg;
            mk_w                       = mrd_q | (3'b001 << e_reg);
        end
    end

    // Face i side of a link, written on a port-like second update
    logic [3*FaceW-1:0] nfi_q;
    logic [2:0]         nvi_q;
    logic [5:0]         nei_q;
    always_ff @(posedge aclk) begin
        if (cmd.lat_i) begin
            nfi_q <= nf_q;
            nvi_q <= nv_q;
            nei_q <= ne_q;
        end else if (cmd.link) begin
            nfi_q[k_reg*FaceW +: FaceW] <= jj;
            nvi_q[k_reg]                <= 1'b1;
            nei_q[k_reg*2 +: 2]         <= e_reg;
        end
    end

    logic i_dirty_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)            i_dirty_reg <= 1'b0;
        else if (cmd.link)       i_dirty_reg <= 1'b1;
        else if (cmd.inc_i)      i_dirty_reg <= 1'b0;
    end

    // Write back: clear writes face i, link writes face j; leaving a linked face i writes its entry
    always_ff @(posedge aclk) begin
        if (adj_we) begin
            nf_mem[adj_addr]   <= nf_w;
            nv_mem[adj_addr]   <= nv_w;
            ne_mem[adj_addr]   <= ne_w;
            mask_mem[adj_addr] <= mk_w;
        end else if (cmd.inc_i && (i_dirty_reg || cmd.link)) begin
            nf_mem[ii]   <= nfi_q;
            nv_mem[ii]   <= nvi_q;
            ne_mem[ii]   <= nei_q;
            mask_mem[ii] <= mask_i_reg;
        end
    end

    // Status
    logic [VertW-1:0] va, vb;
    assign va = vsel(vi_reg, k_reg);
    assign vb = vsel(vi_reg, next_corner(k_reg));

    assign sts.i_done      = (i_reg >= count_reg);
    assign sts.k_last      = (k_reg == 2'd2);
    assign sts.k_matched   = mask_i_reg[k_reg];
    assign sts.j_done      = (j_reg >= count_reg);
    assign sts.j_full_mask = (mrd_q == 3'b111);
    assign sts.e_hit       = (vsel(vrd_q, e_reg) == vb) &&
                             (vsel(vrd_q, next_corner(e_reg)) == va);
    assign sts.e_last      = (e_reg == 2'd2);

    // Entries at or above this mark were never cleared since reset: no neighbor
    logic [CountW-1:0] hw_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg <= '0;
        end else if (cmd.clr_entry && i_reg >= hw_reg) begin
            hw_reg <= i_reg + 1'b1;
        end
    end

    // Read result register
    logic ok_next;
    logic seen_reg;
    assign ok_next = ({1'b0, s_face_index} < count_reg);
    always_ff @(posedge aclk) begin
        if (cmd.rd_req) begin
            ok_reg   <= ok_next;
            seen_reg <= ({1'b0, s_face_index} < hw_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (cmd.out_load) begin
            vld_reg <= 1'b1;
        end else if (m_ready) begin
            vld_reg <= 1'b0;
        end
    end

    logic signed [NbrW-1:0] f0_reg, f1_reg, f2_reg;
    logic [1:0]             e0_reg, e1_reg, e2_reg;
    logic                   r_reg;
    logic                   use_entry;
    assign use_entry = ok_reg && seen_reg;
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            r_reg  <= ok_reg;
            f0_reg <= (use_entry && nv_q[0]) ? NbrW'({1'b0, nf_q[FaceW-1:0]}) : '1;
            f1_reg <= (use_entry && nv_q[1]) ? NbrW'({1'b0, nf_q[2*FaceW-1:FaceW]}) : '1;
            f2_reg <= (use_entry && nv_q[2]) ? NbrW'({1'b0, nf_q[3*FaceW-1:2*FaceW]}) : '1;
            e0_reg <= use_entry ? ne_q[1:0] : 2'd0;
            e1_reg <= use_entry ? ne_q[3:2] : 2'd0;
            e2_reg <= use_entry ? ne_q[5:4] : 2'd0;
        end
    end

    assign out_busy          = vld_reg && !m_ready;
    assign m_valid           = vld_reg;
    assign m_in_range        = r_reg;
    assign m_neighbor_face_0 = f0_reg;
    assign m_neighbor_face_1 = f1_reg;
    assign m_neighbor_face_2 = f2_reg;
    assign m_neighbor_edge_0 = e0_reg;
    assign m_neighbor_edge_1 = e1_reg;
    assign m_neighbor_edge_2 = e2_reg;

endmodule

// ----- sv/triangle_edge_adjacency_unit.sv -----
// Top level of the triangle edge adjacency unit.
// A load is taken in the idle state, which the block keeps until the last face; a read
// holds s_ready low through ST_RWAIT and ST_OUT, and its result beat is registered there.
// The last load starts a build that holds s_ready low while it runs: a clear pass over the
// loaded faces, then per face a fetch and a check of each edge; for each unmatched edge
// a scan over the later faces, one edge compare at a time, plus a link per match, bounded
// by the one read port of the face memories, so the build grows with the square of the face
// count. A mark of how many entries builds have cleared since reset makes entries never
// cleared read as no neighbor, so no clearing pass after reset is needed.
module triangle_edge_adjacency_unit
    import tea_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_command,
    input  logic [VertW-1:0]       s_vertex_0,
    input  logic [VertW-1:0]       s_vertex_1,
    input  logic [VertW-1:0]       s_vertex_2,
    input  logic                   s_last_face,
    input  logic [FaceW-1:0]       s_face_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_in_range,
    output logic signed [NbrW-1:0] m_neighbor_face_0,
    output logic signed [NbrW-1:0] m_neighbor_face_1,
    output logic signed [NbrW-1:0] m_neighbor_face_2,
    output logic [1:0]             m_neighbor_edge_0,
    output logic [1:0]             m_neighbor_edge_1,
    output logic [1:0]             m_neighbor_edge_2
);

    cmd_bus_t cmd;
    sts_bus_t sts;
    logic     out_busy;

    tea_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_last_face (s_last_face),
        .out_busy    (out_busy),
        .sts         (sts),
        .cmd         (cmd)
    );

    tea_dpath u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_vertex_0        (s_vertex_0),
        .s_vertex_1        (s_vertex_1),
        .s_vertex_2        (s_vertex_2),
        .s_face_index      (s_face_index),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .out_busy          (out_busy),
        .m_in_range        (m_in_range),
        .m_neighbor_face_0 (m_neighbor_face_0),
        .m_neighbor_face_1 (m_neighbor_face_1),
        .m_neighbor_face_2 (m_neighbor_face_2),
        .m_neighbor_edge_0 (m_neighbor_edge_0),
        .m_neighbor_edge_1 (m_neighbor_edge_1),
        .m_neighbor_edge_2 (m_neighbor_edge_2)
    );

endmodule

// ----- sv/tea_checker.sv -----
// Port-level checks for the triangle edge adjacency unit, bound to the top level.
module tea_checker
    import tea_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   s_command,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic                   m_in_range,
    input logic signed [NbrW-1:0] m_neighbor_face_0,
    input logic [1:0]             m_neighbor_edge_0
);

    // Result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbor_face_0))
        else $error("result beat changed while stalled");

    // A load never produces a result beat
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_LOAD |=> !m_valid)
        else $error("result after a load");

    // Out-of-range reads report no neighbor
    a_oor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_range |-> m_neighbor_face_0 == -1 && m_neighbor_edge_0 == 2'd0)
        else $error("out-of-range read shows a neighbor");

    // No input taken while a result beat is stalled
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted over stalled result");

endmodule

bind triangle_edge_adjacency_unit tea_checker u_tea_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .s_command         (s_command),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_in_range        (m_in_range),
    .m_neighbor_face_0 (m_neighbor_face_0),
    .m_neighbor_edge_0 (m_neighbor_edge_0)
);

// ----- test/tb.sv -----
// Testbench for the triangle edge adjacency unit: directed and random meshes against a predictor.
`timescale 1ns / 1ps

module tb;
    import tea_pkg::*;

    localparam int StallLimit = 400000;

    // Expected read beat.
    typedef struct {
        logic             in_range;
        logic [NbrW-1:0]  nface [3];
        logic [1:0]       nedge [3];
    } adj_beat_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_command = CMD_LOAD;
    logic [VertW-1:0]       s_vertex_0 = '0;
    logic [VertW-1:0]       s_vertex_1 = '0;
    logic [VertW-1:0]       s_vertex_2 = '0;
    logic                   s_last_face = 1'b0;
    logic [FaceW-1:0]       s_face_index = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_in_range;
    logic signed [NbrW-1:0] m_neighbor_face_0;
    logic signed [NbrW-1:0] m_neighbor_face_1;
    logic signed [NbrW-1:0] m_neighbor_face_2;
    logic [1:0]             m_neighbor_edge_0;
    logic [1:0]             m_neighbor_edge_1;
    logic [1:0]             m_neighbor_edge_2;

    // Predicted mesh state.
    logic [VertW-1:0] mesh_vtx [MaxFaces][3];
    int               adj_face [MaxFaces][3];
    logic [1:0]       adj_edge [MaxFaces][3];
    logic [2:0]       adj_mask [MaxFaces];
    int               mesh_faces;
    bit               mesh_built;

    adj_beat_t expected_adj [$];
    int  errors;
    int  loads_sent, reads_sent, meshes_built, reads_checked;
    int  hold_left;
    bit  steady_send;
    int  idle_cycles;

    triangle_edge_adjacency_unit dut (.*);

    always #5 aclk = ~aclk;

    // Reset and initial store values.
    initial begin
        for (int f = 0; f < MaxFaces; f++) begin
            for (int k = 0; k < 3; k++) begin
                mesh_vtx[f][k] = '0;
                adj_face[f][k] = -1;
                adj_edge[f][k] = '0;
            end
            adj_mask[f] = '0;
        end
        mesh_faces = 0;
        mesh_built = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Link edge k of face fi to the first reversed edge among later faces.
    function automatic void link_edge(int fi, int k);
        logic [VertW-1:0] va, vb;
        va = mesh_vtx[fi][k];
        vb = mesh_vtx[fi][(k + 1) % 3];
        for (int j = fi + 1; j < mesh_faces; j++) begin
            if (adj_mask[j] == 3'b111) continue;
            for (int e = 0; e < 3; e++) begin
                if (mesh_vtx[j][e] == vb && mesh_vtx[j][(e + 1) % 3] == va) begin
                    adj_face[fi][k] = j;
                    adj_edge[fi][k] = 2'(e);
                    adj_mask[fi][k] = 1'b1;
                    adj_face[j][e] = fi;
                    adj_edge[j][e] = 2'(k);
                    adj_mask[j][e] = 1'b1;
                    return;
                end
            end
        end
    endfunction

    function automatic void build_mesh();
        for (int f = 0; f < mesh_faces; f++) begin
            for (int k = 0; k < 3; k++) begin
                adj_face[f][k] = -1;
                adj_edge[f][k] = '0;
            end
            adj_mask[f] = '0;
        end
        for (int f = 0; f < mesh_faces; f++)
            for (int k = 0; k < 3; k++)
                if (!adj_mask[f][k]) link_edge(f, k);
        mesh_built = 1;
        meshes_built++;
    endfunction

    // Update the predictor for one accepted input beat.
    function automatic void predict_beat(cmd_t cmd, logic [VertW-1:0] v0, logic [VertW-1:0] v1,
                                         logic [VertW-1:0] v2, logic last, int idx);
        adj_beat_t b;
        if (cmd == CMD_LOAD) begin
            if (mesh_built) begin
                mesh_faces = 0;
                mesh_built = 0;
            end
            if (mesh_faces < MaxFaces) begin
                mesh_vtx[mesh_faces][0] = v0;
                mesh_vtx[mesh_faces][1] = v1;
                mesh_vtx[mesh_faces][2] = v2;
                mesh_faces++;
            end
            if (last) build_mesh();
            loads_sent++;
        end else begin
            b.in_range = idx < mesh_faces;
            for (int k = 0; k < 3; k++) begin
                b.nface[k] = b.in_range ? NbrW'(adj_face[idx][k]) : '1;
                b.nedge[k] = b.in_range ? adj_edge[idx][k] : 2'd0;
            end
            expected_adj = {expected_adj, b};
            reads_sent++;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_send) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Send one beat and return at the edge where it is accepted.
    task automatic send_beat(cmd_t cmd, logic [VertW-1:0] v0, logic [VertW-1:0] v1,
                             logic [VertW-1:0] v2, logic last, int idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_command    <= cmd;
        s_vertex_0   <= v0;
        s_vertex_1   <= v1;
        s_vertex_2   <= v2;
        s_last_face  <= last;
        s_face_index <= idx[FaceW-1:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(cmd, v0, v1, v2, last, idx);
    endtask

    task automatic load_face(logic [VertW-1:0] v0, logic [VertW-1:0] v1,
                             logic [VertW-1:0] v2, logic last);
        send_beat(CMD_LOAD, v0, v1, v2, last, int'($urandom_range(0, MaxFaces - 1)));
    endtask

    task automatic read_face(int idx);
        send_beat(CMD_READ, VertW'($urandom), VertW'($urandom), VertW'($urandom),
                  1'($urandom_range(0, 1)), idx);
    endtask

    // Sender pause until every read beat has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_adj.size() != 0) @(posedge aclk);
    endtask

    // Receiver: check each beat, then pick the next ready level.
    initial begin
        adj_beat_t b;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_adj.size() == 0) begin
                    $display("%0t: result beat with none expected", $time);
                    errors++;
                end else begin
                    b = expected_adj.pop_front();
                    reads_checked++;
                    check_field("in_range", NbrW'(b.in_range), NbrW'(m_in_range));
                    check_field("neighbor_face_0", b.nface[0], m_neighbor_face_0);
                    check_field("neighbor_face_1", b.nface[1], m_neighbor_face_1);
                    check_field("neighbor_face_2", b.nface[2], m_neighbor_face_2);
                    check_field("neighbor_edge_0", NbrW'(b.nedge[0]), NbrW'(m_neighbor_edge_0));
                    check_field("neighbor_edge_1", NbrW'(b.nedge[1]), NbrW'(m_neighbor_edge_1));
                    check_field("neighbor_edge_2", NbrW'(b.nedge[2]), NbrW'(m_neighbor_edge_2));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady_send) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
            end
        end
    end

    function automatic void check_field(string name, logic [NbrW-1:0] exp_v,
                                        logic [NbrW-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // Reads before any load: all out of range.
    task automatic test_empty_reads();
        read_face(0);
        read_face(MaxFaces - 1);
        read_face(5);
        drain();
    endtask

    // Closed tetrahedron with extreme vertex values, a shared edge, reads around the build.
    task automatic test_directed_mesh();
        logic [VertW-1:0] a, b, c, d;
        a = 16'h0000; b = 16'hFFFF; c = 16'h5555; d = 16'hAAAA;
        load_face(a, b, c, 1'b0);
        load_face(a, d, b, 1'b0);
        read_face(0);               // before the build
        load_face(b, d, c, 1'b0);
        load_face(c, d, a, 1'b0);
        load_face(b, a, d, 1'b1);   // third face on edge a-b, left with no links
        for (int f = 0; f < 6; f++) read_face(f);
        read_face(MaxFaces - 1);
        drain();
        // New mesh starts; stale adjacency shows until the build.
        load_face(c, b, a, 1'b0);
        read_face(0);
        read_face(1);
        load_face(a, b, c, 1'b1);
        read_face(0);
        read_face(1);
        drain();
        load_face(a, a, a, 1'b1);   // degenerate single face
        read_face(0);
        drain();
    endtask

    // Full capacity in face pairs, then a dropped face that carries the last mark.
    task automatic test_capacity();
        logic [VertW-1:0] a;
        steady_send = 1;
        for (int m = 0; m < MaxFaces / 2; m++) begin
            a = VertW'(m * 3);
            load_face(a, a + 16'd1, a + 16'd2, 1'b0);
            load_face(a, a + 16'd2, a + 16'd1, 1'b0);
        end
        load_face(16'h1234, 16'h4321, 16'h0F0F, 1'b1);
        steady_send = 0;
        read_face(0);
        read_face(1);
        read_face(MaxFaces - 2);
        read_face(MaxFaces - 1);
        for (int r = 0; r < 4; r++) read_face($urandom_range(0, MaxFaces - 1));
        drain();
    endtask

    // Receiver holds off while reads keep coming, so the block stalls its input.
    task automatic test_backpressure();
        hold_left = 300;
        for (int r = 0; r < 30; r++) read_face($urandom_range(0, mesh_faces));
        drain();
    endtask

    // Random meshes, with faces that often reuse a reversed edge of an earlier face.
    task automatic test_random_meshes(int beats);
        int start, n, pool, f, p, e;
        logic [VertW-1:0] base, v0, v1, v2;
        bit wide;
        start = loads_sent + reads_sent;
        while (loads_sent + reads_sent - start < beats) begin
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            wide = ($urandom_range(0, 9) == 0);
            pool = $urandom_range(3, 8);
            base = VertW'($urandom);
            steady_send = ($urandom_range(0, 5) == 0);
            for (f = 0; f < n; f++) begin
                if (wide) begin
                    v0 = VertW'($urandom); v1 = VertW'($urandom); v2 = VertW'($urandom);
                end else if (f > 0 && $urandom_range(0, 1)) begin
                    p = mesh_faces - 1 - int'($urandom_range(0, mesh_faces - 1));
                    e = $urandom_range(0, 2);
                    v0 = mesh_vtx[p][(e + 1) % 3];
                    v1 = mesh_vtx[p][e];
                    v2 = base + VertW'($urandom_range(0, pool));
                end else begin
                    v0 = base + VertW'($urandom_range(0, pool));
                    v1 = base + VertW'($urandom_range(0, pool));
                    v2 = base + VertW'($urandom_range(0, pool));
                end
                if ($urandom_range(0, 9) == 0) read_face($urandom_range(0, MaxFaces - 1));
                load_face(v0, v1, v2, f == n - 1);
            end
            for (int r = $urandom_range(2, 10); r > 0; r--)
                read_face(($urandom_range(0, 4) == 0) ? $urandom_range(0, MaxFaces - 1)
                                                      : $urandom_range(0, n));
            steady_send = 0;
            if ($urandom_range(0, 3) == 0) drain();
        end
        drain();
    endtask

    initial begin
        errors = 0;
        hold_left = 0;
        steady_send = 0;
        idle_cycles = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(posedge aclk);
        test_empty_reads();
        test_directed_mesh();
        test_random_meshes(60);
        test_backpressure();
        test_capacity();
        test_random_meshes(60);
        repeat (40) @(posedge aclk);
        $display("Covered %0d face loads, %0d reads (%0d checked), %0d mesh builds,",
                 loads_sent, reads_sent, reads_checked, meshes_built);
        $display("including a full-capacity mesh, stale reads and a long output stall.");
        if (errors == 0 && expected_adj.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
